// ===== rtl/srcb_pkg.sv =====
`default_nettype none

package srcb_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int PRICE_BITS    = 32;

    localparam int WIN_W      = 6;
    localparam int CELLS      = HISTORY_DEPTH - 1;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int SUM_W      = PRICE_BITS + $clog2(HISTORY_DEPTH);
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int PROD_W     = SUM_W + WIN_W;
    localparam int PROFIT_W   = 48;
    localparam int IN_TDATA_W = ((PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RSI   = CFG_IDX_W'(2);

    localparam logic [WIN_W-1:0] SHORT_RESET = WIN_W'(5);
    localparam logic [WIN_W-1:0] LONG_RESET  = WIN_W'(20);
    localparam logic [WIN_W-1:0] RSI_RESET   = WIN_W'(14);

    typedef enum logic [1:0] {
        TRADE_NONE  = 2'd0,
        TRADE_ENTER = 2'd1,
        TRADE_EXIT  = 2'd2
    } trade_t;

    // prefix sums held by one chain cell
    typedef struct packed {
        logic [SUM_W-1:0] psum;
        logic [SUM_W-1:0] gsum;
        logic [SUM_W-1:0] lsum;
    } cell_t;

    typedef struct packed {
        logic                  restart;
        logic                  decided;
        logic [PRICE_BITS-1:0] price;
        logic [PROD_W-1:0]     lhs;
        logic [PROD_W-1:0]     rhs;
        logic                  rsi_ok;
    } dec_in_t;

    typedef struct packed {
        trade_t                      trade;
        logic                        holding;
        logic signed [PROFIT_W-1:0]  profit;
        logic                        warmed;
    } dec_out_t;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WIN_W'(1);
        end else if (int'(w) > HISTORY_DEPTH - 1) begin
            r = WIN_W'(HISTORY_DEPTH - 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srcb_cell.sv =====
`default_nettype none

module srcb_cell
    import srcb_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  shift,
    input  wire cell_t left,
    input  wire cell_t sample,
    output cell_t      q
);

    cell_t q_reg;
    cell_t q_next;

    // new window of length k+1 = newest term + old window of length k
    always_comb begin
        q_next.psum = left.psum + sample.psum;
        q_next.gsum = left.gsum + sample.gsum;
        q_next.lsum = left.lsum + sample.lsum;
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== rtl/srcb_decide.sv =====
`default_nettype none

module srcb_decide
    import srcb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire dec_in_t din,
    output logic         out_valid,
    output dec_out_t     dout
);

    localparam logic signed [PROFIT_W-1:0] PROFIT_MAX = {1'b0, {(PROFIT_W-1){1'b1}}};
    localparam logic signed [PROFIT_W-1:0] PROFIT_MIN = {1'b1, {(PROFIT_W-1){1'b0}}};

    logic                       valid_reg;
    logic                       open_reg,   open_next;
    logic [PRICE_BITS-1:0]      entry_reg,  entry_next;
    logic signed [PROFIT_W-1:0] profit_reg, profit_next;
    dec_out_t                   out_reg,    out_next;

    logic                       open_cur;
    logic [PRICE_BITS-1:0]      entry_cur;
    logic signed [PROFIT_W-1:0] profit_cur;
    logic                       above, below;
    logic signed [PRICE_BITS:0] diff;
    logic signed [PROFIT_W:0]   sum_ext;
    logic signed [PROFIT_W-1:0] sum_sat;
    trade_t                     trade;

    always_comb begin
        open_cur   = din.restart ? 1'b0 : open_reg;
        entry_cur  = din.restart ? '0 : entry_reg;
        profit_cur = din.restart ? '0 : profit_reg;

        above = din.lhs > din.rhs;
        below = din.lhs < din.rhs;

        diff    = $signed({1'b0, din.price}) - $signed({1'b0, entry_cur});
        sum_ext = $signed({profit_cur[PROFIT_W-1], profit_cur})
                + $signed({{(PROFIT_W-PRICE_BITS){diff[PRICE_BITS]}}, diff});
        if (sum_ext[PROFIT_W] != sum_ext[PROFIT_W-1]) begin
            sum_sat = sum_ext[PROFIT_W] ? PROFIT_MIN : PROFIT_MAX;
        end else begin
            sum_sat = sum_ext[PROFIT_W-1:0];
        end

        open_next   = open_cur;
        entry_next  = entry_cur;
        profit_next = profit_cur;
        trade       = TRADE_NONE;
        if (din.decided) begin
            if (!open_cur && above && din.rsi_ok) begin
                open_next  = 1'b1;
                entry_next = din.price;
                trade      = TRADE_ENTER;
            end else if (open_cur && below) begin
                open_next   = 1'b0;
                profit_next = sum_sat;
                trade       = TRADE_EXIT;
            end
        end

        out_next.trade   = trade;
        out_next.holding = open_next;
        out_next.profit  = profit_next;
        out_next.warmed  = din.decided;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            open_reg   <= 1'b0;
            entry_reg  <= '0;
            profit_reg <= '0;
        end else if (en) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                open_reg   <= open_next;
                entry_reg  <= entry_next;
                profit_reg <= profit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = out_reg;

endmodule

`default_nettype wire

// ===== rtl/sma_rsi_crossover_backtest.sv =====
`default_nettype none

// SMA crossover backtest with an RSI filter. One closing price word per clock is
// accepted and one result word per price leaves the stage 3 output register; a stall on
// the result side holds the whole pipe. A row of cells keeps running prefix sums
// of price, gain and loss for every window length, advanced once per accepted
// word, so any window setting is read out by a tap select with no clearing pass
// and no recompute after a register write. Windows read 0 as 1. Write the
// window registers only while no word is in flight.
module sma_rsi_crossover_backtest
    import srcb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // close_price
    input  wire logic                   s_tuser,   // restart

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // profit_sum
    output logic [OUT_TUSER_W-1:0]      m_tuser,   // trade_event[1:0], holding, warmed_up

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [WIN_W-1:0]       cfg_data
);

    logic [WIN_W-1:0] short_reg, long_reg, rsi_reg;
    logic [WIN_W-1:0] s_win, l_win, r_win, lr_max;

    logic             en, accept, out_valid;
    logic [PRICE_BITS-1:0] price_in;
    logic             restart_in;

    logic [CNT_W-1:0] seen_reg, seen_next, seen_cur, need;
    logic             decided, short_ok;
    logic [PRICE_BITS-1:0] last_price_reg;

    logic             v1_reg, restart1_reg, decided1_reg, short_ok1_reg;
    logic [PRICE_BITS-1:0] price1_reg;

    logic             v2_reg;
    dec_in_t          dec_reg, dec_next;
    dec_out_t         dout;

    cell_t            sample;
    cell_t            chain_q    [CELLS];
    cell_t            chain_left [CELLS];

    logic [IDX_W-1:0] sel_s, sel_l, sel_r;
    logic [SUM_W-1:0] short_sum;

    // config port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg <= SHORT_RESET;
            long_reg  <= LONG_RESET;
            rsi_reg   <= RSI_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SHORT: short_reg <= cfg_data;
                REG_LONG:  long_reg  <= cfg_data;
                REG_RSI:   rsi_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign s_win  = clamp_window(short_reg);
    assign l_win  = clamp_window(long_reg);
    assign r_win  = clamp_window(rsi_reg);
    assign lr_max = (l_win > r_win) ? l_win : r_win;

    // pipe moves when the output register is free
    assign en       = !out_valid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign price_in   = s_tdata[PRICE_BITS-1:0];
    assign restart_in = s_tuser;

    // stage 1: sample count, warm-up test, chain update
    always_comb begin
        seen_cur = restart_in ? '0 : seen_reg;
        need     = CNT_W'(lr_max) + CNT_W'(1);
        decided  = seen_cur >= need;
        short_ok = {1'b0, CNT_W'(s_win)} <= ({1'b0, seen_cur} + (CNT_W+1)'(1));
        if (seen_cur < CNT_W'(HISTORY_DEPTH)) begin
            seen_next = seen_cur + CNT_W'(1);
        end else begin
            seen_next = seen_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (accept) begin
            seen_reg <= seen_next;
        end
    end

    // first word of a series leaves a junk change in cell 0; no window reaches it
    always_comb begin
        sample.psum = SUM_W'(price_in);
        if (price_in > last_price_reg) begin
            sample.gsum = SUM_W'(price_in - last_price_reg);
            sample.lsum = '0;
        end else begin
            sample.gsum = '0;
            sample.lsum = SUM_W'(last_price_reg - price_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_price_reg <= price_in;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CELLS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign chain_left[k] = '0;
            end else begin : g_body
                assign chain_left[k] = chain_q[k-1];
            end
            srcb_cell u_cell (
                .aclk   (aclk),
                .shift  (accept),
                .left   (chain_left[k]),
                .sample (sample),
                .q      (chain_q[k])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            price1_reg    <= price_in;
            restart1_reg  <= restart_in;
            decided1_reg  <= decided;
            short_ok1_reg <= short_ok;
        end
    end

    // stage 2: tap select and cross-multiply
    assign sel_s = IDX_W'(s_win - WIN_W'(1));
    assign sel_l = IDX_W'(l_win - WIN_W'(1));
    assign sel_r = IDX_W'(r_win - WIN_W'(1));

    always_comb begin
        short_sum        = short_ok1_reg ? chain_q[sel_s].psum : '0;
        dec_next.restart = restart1_reg;
        dec_next.decided = decided1_reg;
        dec_next.price   = price1_reg;
        dec_next.lhs     = PROD_W'(short_sum) * PROD_W'(l_win);
        dec_next.rhs     = PROD_W'(chain_q[sel_l].psum) * PROD_W'(s_win);
        dec_next.rsi_ok  = (chain_q[sel_r].lsum == '0)
                        || (chain_q[sel_r].gsum > chain_q[sel_r].lsum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && v1_reg) begin
            dec_reg <= dec_next;
        end
    end

    // stage 3: position logic and output register
    srcb_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .din       (dec_reg),
        .out_valid (out_valid),
        .dout      (dout)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_TDATA_W'(dout.profit);
    assign m_tuser  = {dout.warmed, dout.holding, dout.trade};

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srcb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam longint PROFIT_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint PROFIT_BOTTOM = -PROFIT_TOP - 1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // close_price
    logic                   s_tuser   = 1'b0; // restart
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // profit_sum
    logic [OUT_TUSER_W-1:0] m_tuser;          // trade_event[1:0], holding, warmed_up
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WIN_W-1:0]       cfg_data  = '0;

    sma_rsi_crossover_backtest dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    typedef struct {
        logic [PRICE_BITS-1:0] price;
        logic                  restart;
    } tick_t;

    tick_t    price_feed[$];
    dec_out_t expected_results[$];
    tick_t    next_tick;
    dec_out_t want;

    // backtest state as the block should hold it
    logic [PRICE_BITS-1:0] hist [HISTORY_DEPTH];
    int unsigned           hist_head;
    int unsigned           hist_count;
    logic                  pos_open;
    logic [PRICE_BITS-1:0] entry_level;
    longint                profit_total;
    logic [WIN_W-1:0]      win_short = SHORT_RESET;
    logic [WIN_W-1:0]      win_long  = LONG_RESET;
    logic [WIN_W-1:0]      win_rsi   = RSI_RESET;

    bit          no_idle    = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_taken = 1'b0;
    int          tx_gap     = 0;
    int          rx_gap     = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int unsigned errors     = 0;
    int unsigned words_out  = 0;
    int unsigned entries    = 0;
    int unsigned exits      = 0;
    int unsigned decisions  = 0;
    int unsigned restarts   = 0;
    int unsigned phases     = 0;

    function automatic void clear_series();
        int i;
        for (i = 0; i < HISTORY_DEPTH; i++) hist[i] = '0;
        hist_head    = 0;
        hist_count   = 0;
        pos_open     = 1'b0;
        entry_level  = '0;
        profit_total = 0;
    endfunction

    function automatic int unsigned eff_window(input logic [WIN_W-1:0] w);
        int unsigned v;
        v = w;
        if (v < 1) v = 1;
        if (v > HISTORY_DEPTH - 1) v = HISTORY_DEPTH - 1;
        return v;
    endfunction

    function automatic longint unsigned recent(input int unsigned k);
        return hist[(hist_head + HISTORY_DEPTH - k) % HISTORY_DEPTH];
    endfunction

    function automatic longint unsigned window_total(input int unsigned w);
        longint unsigned acc;
        int unsigned     k;
        acc = 0;
        for (k = 0; k < w; k++) acc += recent(k);
        return acc;
    endfunction

    function automatic dec_out_t backtest_step(input logic [PRICE_BITS-1:0] price,
                                               input logic restart);
        int unsigned     s, l, r, need, seen_prior, k;
        longint unsigned short_sum, long_sum, gains, losses, cur, prev;
        longint          diff, sum;
        logic            above, below, rsi_ok;
        dec_out_t        res;
        if (restart) clear_series();
        s = eff_window(win_short);
        l = eff_window(win_long);
        r = eff_window(win_rsi);
        need = ((l > r) ? l : r) + 1;
        seen_prior = hist_count;
        if (seen_prior > 0) hist_head = (hist_head + 1) % HISTORY_DEPTH;
        hist[hist_head] = price;
        res.trade  = TRADE_NONE;
        res.warmed = 1'b0;
        if (seen_prior >= need) begin
            res.warmed = 1'b1;
            // short window not yet filled reads as zero
            short_sum = (s <= seen_prior + 1) ? window_total(s) : 0;
            long_sum  = window_total(l);
            gains  = 0;
            losses = 0;
            for (k = 0; k < r; k++) begin
                cur  = recent(k);
                prev = recent(k + 1);
                if (cur > prev) gains += cur - prev;
                else losses += prev - cur;
            end
            above  = (short_sum * l) > (long_sum * s);
            below  = (short_sum * l) < (long_sum * s);
            rsi_ok = (losses == 0) || (gains > losses);
            if (!pos_open && above && rsi_ok) begin
                pos_open    = 1'b1;
                entry_level = price;
                res.trade   = TRADE_ENTER;
            end else if (pos_open && below) begin
                diff = price;
                diff = diff - entry_level;
                sum  = profit_total + diff;
                if (sum > PROFIT_TOP) sum = PROFIT_TOP;
                if (sum < PROFIT_BOTTOM) sum = PROFIT_BOTTOM;
                profit_total = sum;
                pos_open     = 1'b0;
                res.trade    = TRADE_EXIT;
            end
        end
        if (hist_count < HISTORY_DEPTH) hist_count++;
        res.holding = pos_open;
        res.profit  = profit_total[PROFIT_W-1:0];
        return res;
    endfunction

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch in %s at word %0d: expected %0h, got %0h",
                         name, words_out, exp_v, act_v);
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        backtest_step(s_tdata[PRICE_BITS-1:0], s_tuser));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (price_feed.size() > 0) begin
                    next_tick = price_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_tick.price;
                    s_tuser  <= next_tick.restart;
                    tx_gap   = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result word %0d: tuser %0h tdata %0h",
                                 words_out, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("trade_event", want.trade, m_tuser[1:0]);
                    check_field("holding", want.holding, m_tuser[2]);
                    check_field("warmed_up", want.warmed, m_tuser[3]);
                    check_field("profit_sum", unsigned'(want.profit), m_tdata);
                    if (want.warmed) decisions++;
                    if (want.trade == TRADE_ENTER) entries++;
                    if (want.trade == TRADE_EXIT) exits++;
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_tick(input logic [PRICE_BITS-1:0] price, input logic restart);
        tick_t t;
        t.price   = price;
        t.restart = restart;
        if (restart) restarts++;
        price_feed.insert(price_feed.size(), t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SHORT: win_short = val;
            REG_LONG:  win_long  = val;
            REG_RSI:   win_rsi   = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (price_feed.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic queue_noise(input int n);
        int k;
        logic [PRICE_BITS-1:0] p;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0:       p = '0;
                1:       p = '1;
                default: p = $urandom;
            endcase
            push_tick(p, $urandom_range(0, 3) == 0);
        end
    endtask

    // trending walk, direction flips on a run length tied to the long window
    task automatic queue_walk(input int n, input bit fresh, input int span);
        longint p, step, top;
        int     dir, run, shift, k;
        top   = 64'h0000_0000_FFFF_FFFF;
        p     = $urandom;
        shift = $urandom_range(0, 30);
        dir   = $urandom_range(0, 1) ? 1 : -1;
        run   = $urandom_range(2, 4 + span);
        for (k = 0; k < n; k++) begin
            if (run == 0) begin
                dir = -dir;
                run = $urandom_range(2, 4 + span);
            end
            run--;
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << shift);
            p = p + dir * step;
            if (p < 0) begin
                p   = 0;
                dir = 1;
            end
            if (p > top) begin
                p   = top;
                dir = -1;
            end
            push_tick(p[PRICE_BITS-1:0], fresh && k == 0);
        end
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] ws, input logic [WIN_W-1:0] wl,
                             input logic [WIN_W-1:0] wr, input int n, input bit calm);
        int need, span, seg, left;
        write_reg(REG_SHORT, ws);
        write_reg(REG_LONG, wl);
        write_reg(REG_RSI, wr);
        no_idle = calm;
        span = eff_window(wl);
        need = eff_window(ws);
        if (span > need) need = span;
        if (eff_window(wr) > need) need = eff_window(wr);
        need++;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 6) == 0) begin
                seg = $urandom_range(1, 6);
                if (seg > left) seg = left;
                queue_noise(seg);
            end else begin
                seg = need + $urandom_range(5, 40);
                if (seg > left) seg = left;
                queue_walk(seg, $urandom_range(0, 9) < 7, span);
            end
            left -= seg;
        end
        wait_drained();
        phases++;
    endtask

    initial begin
        clear_series();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset windows: flat warm-up, then a jump to full scale enters
        push_tick(32'h0000_0000, 1'b1);
        repeat (20) push_tick(32'h0000_0000, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b0);
        push_tick(32'h0000_0000, 1'b0);
        wait_drained();

        // shrink windows while holding; zero short window acts as one
        write_reg(REG_SHORT, 6'd0);
        write_reg(REG_LONG, 6'd2);
        write_reg(REG_RSI, 6'd1);
        write_reg(REG_UNUSED, 6'd63);
        push_tick(32'h8000_0000, 1'b0);
        push_tick(32'h0000_0000, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b0);
        push_tick(32'h8000_0000, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b0);
        push_tick(32'h0000_0005, 1'b1);
        wait_drained();

        run_phase(6'd3, 6'd8, 6'd5, 70, 1'b0);
        run_phase(6'd1, 6'd2, 6'd1, 60, 1'b0);
        run_phase(6'd2, 6'd3, 6'd2, 60, 1'b1);
        hold_req = 1'b1;
        run_phase(6'd5, 6'd20, 6'd14, 90, 1'b0);
        run_phase(6'd63, 6'd1, 6'd1, 130, 1'b0);
        run_phase(6'd63, 6'd63, 6'd63, 150, 1'b0);
        run_phase(6'd4, 6'd0, 6'd3, 60, 1'b0);
        run_phase(6'd6, 6'd12, 6'd0, 60, 1'b0);
        run_phase(6'd1, 6'd62, 6'd62, 130, 1'b0);
        run_phase(6'd62, 6'd62, 6'd1, 130, 1'b1);
        run_phase(WIN_W'($urandom_range(0, 12)), WIN_W'($urandom_range(0, 24)),
                  WIN_W'($urandom_range(0, 16)), 60, 1'b0);
        run_phase(WIN_W'($urandom_range(0, 12)), WIN_W'($urandom_range(0, 24)),
                  WIN_W'($urandom_range(0, 16)), 60, 1'b0);
        run_phase(6'd10, 6'd30, 6'd20, 60, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d result words over %0d window settings, %0d restarts",
                 words_out, phases + 2, restarts);
        $display("%0d decisions, %0d entries, %0d exits, final profit %0d, %0d errors",
                 decisions, entries, exits, profit_total, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srcb_pkg.sv
rtl/srcb_cell.sv
rtl/srcb_decide.sv
rtl/sma_rsi_crossover_backtest.sv
test/tb.sv
